[rtl/scc_pkg.sv]
// scc_pkg: shared types, operation codes and shape tables for the sprite column compositor.
// Depends on nothing; used by scc_slot_unit and sprite_column_compositor.
package scc_pkg;

	localparam int unsigned SHAPE_COUNT = 5;

	localparam logic [1:0] OP_RENDER = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// input beat, last field in the lowest bits
	typedef struct packed {
		logic [4:0] pad;
		logic [3:0] row_period;
		logic [3:0] column_period;
		logic       row_direction;
		logic       column_direction;
		logic [7:0] life;
		logic [2:0] color;
		logic [7:0] start_column;
		logic [2:0] shape;
		logic [2:0] slot;
		logic [7:0] column;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] blue_bits;
		logic [7:0] green_bits;
		logic [7:0] red_bits;
	} out_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one sprite slot as the shared unit sees it
	typedef struct packed {
		logic [7:0] life;
		logic [2:0] shape;
		logic [7:0] pos;
		logic [2:0] roff;
		logic [2:0] color;
		logic       cdir;
		logic       rdir;
		logic [3:0] cper;
		logic [3:0] rper;
		logic [3:0] ccnt;
		logic [3:0] rcnt;
	} slot_t;

	function automatic logic [7:0] shape_line(input logic [2:0] sh, input logic [1:0] off);
		logic [31:0] rows;
		unique case (sh)
			3'd0:    rows = 32'h0000_1818;
			3'd1:    rows = 32'h0010_3810;
			3'd2:    rows = 32'h0818_1808;
			3'd3:    rows = 32'h2418_1824;
			3'd4:    rows = 32'h1824_2418;
			default: rows = 32'h0000_0000;
		endcase
		return rows[8*off +: 8];
	endfunction

	function automatic logic [2:0] shape_width(input logic [2:0] sh);
		unique case (sh)
			3'd0:    return 3'd2;
			3'd1:    return 3'd3;
			3'd2, 3'd3, 3'd4: return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic signed [2:0] shape_rmin(input logic [2:0] sh);
		unique case (sh)
			3'd3, 3'd4: return -3'sd2;
			default:    return -3'sd3;
		endcase
	endfunction

	function automatic logic signed [2:0] shape_rmax(input logic [2:0] sh);
		unique case (sh)
			3'd1, 3'd3, 3'd4: return 3'sd2;
			default:          return 3'sd3;
		endcase
	endfunction

endpackage

[rtl/scc_slot_unit.sv]
// scc_slot_unit: shared per-slot datapath, one sprite per cycle.
// Render composite step and tick motion update. Depends on scc_pkg.
module scc_slot_unit #(
	parameter int unsigned SCREEN_COLUMNS = 256
) (
	input  scc_pkg::slot_t slot_in,
	input  logic [7:0]     cur_col,
	input  scc_pkg::rgb_t  acc_in,
	output scc_pkg::slot_t slot_out,
	output scc_pkg::rgb_t  acc_out
);

	localparam logic [8:0] SC9 = 9'(SCREEN_COLUMNS);
	localparam logic [7:0] LAST_COL = 8'(SCREEN_COLUMNS - 1);

	logic              live;
	logic [8:0]        dif;
	logic [8:0]        offs;
	logic              hit;
	logic [7:0]        line;
	logic [7:0]        shifted;
	logic [7:0]        rev;
	logic [2:0]        neg_r;
	logic [3:0]        cc;
	logic [3:0]        rc;
	logic [7:0]        life_dec;
	logic [7:0]        pos_next;
	logic signed [2:0] r_new;

	assign live = (slot_in.life != 8'd0);

	// render: column distance modulo screen width, then shift and flip the line
	always_comb begin
		dif = {1'b0, cur_col} - {1'b0, slot_in.pos};
		offs = dif[8] ? (dif + SC9) : dif;
		hit = live && (slot_in.shape < 3'(scc_pkg::SHAPE_COUNT))
			&& (offs < {6'd0, scc_pkg::shape_width(slot_in.shape)});
		line = scc_pkg::shape_line(slot_in.shape, offs[1:0]);
		neg_r = 3'd0 - slot_in.roff;
		if (!slot_in.roff[2] && slot_in.roff != 3'd0) begin
			shifted = line >> slot_in.roff;
		end else begin
			shifted = line << neg_r;
		end
		for (int i = 0; i < 8; i++) begin
			rev[i] = shifted[7 - i];
		end
		acc_out = acc_in;
		if (hit) begin
			acc_out.red   = (acc_in.red & ~rev) | (slot_in.color[2] ? rev : 8'd0);
			acc_out.green = (acc_in.green & ~rev) | (slot_in.color[1] ? rev : 8'd0);
			acc_out.blue  = (acc_in.blue & ~rev) | (slot_in.color[0] ? rev : 8'd0);
		end
	end

	// tick: counters, life, column move and row bounce
	always_comb begin
		slot_out = slot_in;
		cc = slot_in.ccnt + 4'd1;
		rc = slot_in.rcnt + 4'd1;
		life_dec = slot_in.life - 8'd1;
		if (slot_in.cdir) begin
			pos_next = (slot_in.pos == 8'd0) ? LAST_COL : slot_in.pos - 8'd1;
		end else begin
			pos_next = (({1'b0, slot_in.pos} + 9'd1) == SC9) ? 8'd0 : slot_in.pos + 8'd1;
		end
		r_new = $signed(slot_in.roff + (slot_in.rdir ? 3'b111 : 3'b001));
		if (live) begin
			if (cc >= slot_in.cper) begin
				slot_out.life = life_dec;
				if (life_dec != 8'd0) begin
					slot_out.pos = pos_next;
					cc = 4'd0;
				end
			end
			if (rc >= slot_in.rper) begin
				rc = 4'd0;
				slot_out.roff = r_new;
				if (r_new >= scc_pkg::shape_rmax(slot_in.shape)
					|| r_new <= scc_pkg::shape_rmin(slot_in.shape)) begin
					slot_out.rdir = ~slot_in.rdir;
				end
			end
			slot_out.ccnt = cc;
			slot_out.rcnt = rc;
		end
	end

endmodule

[rtl/sprite_column_compositor.sv]
// sprite_column_compositor: sprite table, slot sequencer and output register.
// Depends on scc_pkg and scc_slot_unit.

// Sprite compositor for a column-scanned display 8 pixels tall. Each input beat carries an
// operation in s_tuser: render (0) composites the live sprites covering one column into
// bit-reversed red/green/blue bytes, slot 0 first and later slots on top; tick (1) advances
// counters, life, column position and row bounce of every live sprite; load (2) writes one
// slot and zeroes its row offset and counters. Only render produces an output beat; code 3
// and loads to a slot beyond the table are dropped. Column values are reduced modulo
// SCREEN_COLUMNS by repeated subtraction. One shared slot unit visits one sprite per cycle.
// The input is not ready while a beat is in progress. A finished render waits in the output
// register; the next beat can be accepted while it is held, and a following render stalls
// at its end only until that register is free.
module sprite_column_compositor #(
	parameter int unsigned SPRITE_SLOTS   = 8,
	parameter int unsigned SCREEN_COLUMNS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] column, [10:8] slot, [13:11] shape, [21:14] start_column, [24:22] color,
	// [32:25] life, [33] column_direction, [34] row_direction, [38:35] column_period,
	// [42:39] row_period, [47:43] zero
	input  logic [47:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] red_bits, [15:8] green_bits, [23:16] blue_bits
	output logic [23:0] m_tdata
);

	localparam int unsigned SW = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_IDX = SW'(SPRITE_SLOTS - 1);
	localparam logic [8:0] SC9 = 9'(SCREEN_COLUMNS);
	localparam logic [7:0] SC8 = 8'(SCREEN_COLUMNS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic [SW-1:0]     idx_q;
	logic [7:0]        val_q;
	scc_pkg::rgb_t     acc_q;
	logic              m_tvalid_q;
	scc_pkg::out_beat_t out_q;
	scc_pkg::in_beat_t in_q;
	scc_pkg::in_beat_t in_beat;

	// sprite table: life resets to zero (all slots dead), the rest is written by load and tick
	logic [7:0]        life_q [SPRITE_SLOTS];
	scc_pkg::slot_t    tbl_q  [SPRITE_SLOTS];

	scc_pkg::slot_t    cur_slot;
	scc_pkg::slot_t    next_slot;
	scc_pkg::rgb_t     acc_next;
	scc_pkg::slot_t    load_slot;

	logic              s_hs;
	logic              reduce_more;
	logic              load_ok;
	logic              tick_wr;
	logic              load_wr;
	logic              out_free;

	assign in_beat  = scc_pkg::in_beat_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign s_hs     = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign reduce_more = ({1'b0, val_q} >= SC9);
	assign load_ok     = ({3'd0, in_q.slot} < 6'(SPRITE_SLOTS));
	assign load_wr     = (state_q == ST_REDUCE) && !reduce_more
		&& (op_q == scc_pkg::OP_LOAD) && load_ok;
	assign tick_wr     = (state_q == ST_WALK) && (op_q == scc_pkg::OP_TICK);

	always_comb begin
		cur_slot = tbl_q[idx_q];
		cur_slot.life = life_q[idx_q];
	end

	always_comb begin
		load_slot.life  = in_q.life;
		load_slot.shape = in_q.shape;
		load_slot.pos   = val_q;
		load_slot.roff  = 3'd0;
		load_slot.color = in_q.color;
		load_slot.cdir  = in_q.column_direction;
		load_slot.rdir  = in_q.row_direction;
		load_slot.cper  = in_q.column_period;
		load_slot.rper  = in_q.row_period;
		load_slot.ccnt  = 4'd0;
		load_slot.rcnt  = 4'd0;
	end

	scc_slot_unit #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS)
	) u_unit (
		.slot_in (cur_slot),
		.cur_col (val_q),
		.acc_in  (acc_q),
		.slot_out(next_slot),
		.acc_out (acc_next)
	);

	// beat payload, held for the whole operation
	always_ff @(posedge clk) begin
		if (s_hs) begin
			in_q <= in_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SPRITE_SLOTS; i++) begin
				life_q[i] <= 8'd0;
			end
		end else if (load_wr) begin
			life_q[SW'(in_q.slot)] <= in_q.life;
		end else if (tick_wr) begin
			life_q[idx_q] <= next_slot.life;
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			tbl_q[SW'(in_q.slot)] <= load_slot;
		end else if (tick_wr) begin
			tbl_q[idx_q] <= next_slot;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= scc_pkg::OP_RENDER;
			idx_q      <= '0;
			val_q      <= 8'd0;
			acc_q      <= '0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			// flush reloads the register itself when it hands a beat over
			if (m_tvalid_q && m_tready && state_q != ST_FLUSH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					acc_q <= '0;
					if (s_hs) begin
						op_q <= s_tuser;
						unique case (s_tuser)
							scc_pkg::OP_RENDER: begin
								val_q   <= in_beat.column;
								state_q <= ST_REDUCE;
							end
							scc_pkg::OP_LOAD: begin
								val_q   <= in_beat.start_column;
								state_q <= ST_REDUCE;
							end
							scc_pkg::OP_TICK: state_q <= ST_WALK;
							default:          state_q <= ST_IDLE;
						endcase
					end
				end
				ST_REDUCE: begin
					if (reduce_more) begin
						val_q <= val_q - SC8;
					end else if (op_q == scc_pkg::OP_RENDER) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					acc_q <= acc_next;
					idx_q <= idx_q + SW'(1);
					if (idx_q == LAST_IDX) begin
						state_q <= (op_q == scc_pkg::OP_RENDER) ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_q.red_bits   <= acc_q.red;
						out_q.green_bits <= acc_q.green;
						out_q.blue_bits  <= acc_q.blue;
						m_tvalid_q       <= 1'b1;
						state_q          <= ST_IDLE;
					end else if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a new output beat only comes out of the flush step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FLUSH))
		else $error("output beat raised outside flush");

	// the slot walk never runs past the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q <= LAST_IDX))
		else $error("slot index beyond table");

	// walking uses a column already reduced below the screen width
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && op_q == scc_pkg::OP_RENDER) |-> ({1'b0, val_q} < SC9))
		else $error("render column not reduced");

	// a flush that finds the output register free always hands a beat over
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("flush lost a render result");

endmodule

[sim/sprite_column_compositor_tb.sv]
// Self-checking bench for sprite_column_compositor: directed table, then random load/tick/render/unused
// traffic with random stalls on both stream sides. Depends on scc_pkg and the RTL top only.
module sprite_column_compositor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_RENDER  = scc_pkg::OP_RENDER;
	localparam logic [1:0] OP_TICK    = scc_pkg::OP_TICK;
	localparam logic [1:0] OP_LOAD    = scc_pkg::OP_LOAD;
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         SLOTS      = 8;
	localparam int         RAND_BEATS = 1000;
	localparam int         HOLD_CYC   = 400;
	localparam int         DRAIN_CYC  = 40;
	localparam int         CYCLE_CAP  = 400000;

	// one beat as the driver sees it; want is used only when typed is set
	typedef struct packed {
		logic [1:0]        op;
		scc_pkg::in_beat_t data;
		logic              typed;
		scc_pkg::rgb_t     want;
	} beat_t;

	// directed row: op, column, slot, shape, start, color, life, cdir, rdir, cper, rper,
	// typed, red, green, blue
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] column;
		logic [2:0] slot;
		logic [2:0] shape;
		logic [7:0] start;
		logic [2:0] color;
		logic [7:0] life;
		logic       cdir;
		logic       rdir;
		logic [3:0] cper;
		logic [3:0] rper;
		logic       typed;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	// sprite table mirror
	logic [7:0] life_q  [SLOTS];
	logic [2:0] shape_q [SLOTS];
	logic [7:0] pos_q   [SLOTS];
	logic [2:0] roff_q  [SLOTS];
	logic [2:0] color_q [SLOTS];
	logic       cdir_q  [SLOTS];
	logic       rdir_q  [SLOTS];
	logic [3:0] cper_q  [SLOTS];
	logic [3:0] rper_q  [SLOTS];
	logic [3:0] ccnt_q  [SLOTS];
	logic [3:0] rcnt_q  [SLOTS];

	// glyph rows per column offset, widths and row-offset bounce limits
	logic [7:0] glyph [5][4] = '{
		'{8'h18, 8'h18, 8'h00, 8'h00},
		'{8'h10, 8'h38, 8'h10, 8'h00},
		'{8'h08, 8'h18, 8'h18, 8'h08},
		'{8'h24, 8'h18, 8'h18, 8'h24},
		'{8'h18, 8'h24, 8'h24, 8'h18}
	};
	int glyph_w  [5] = '{2, 3, 4, 4, 4};
	int glyph_lo [5] = '{-3, -3, -3, -2, -2};
	int glyph_hi [5] = '{3, 2, 3, 2, 2};

	scc_pkg::rgb_t      column_px_q [$];
	int                 errors = 0;
	int                 cycles = 0;
	bit                 send_idle = 1'b1;
	bit                 recv_idle = 1'b1;
	bit                 hold_req  = 1'b0;
	logic [7:0]         cluster_base = 8'd0;
	scc_pkg::rgb_t      mon_want;
	scc_pkg::out_beat_t mon_got;

	stim_row_t dir_tab [26] = '{
		// empty table renders black at both screen edges
		'{OP_RENDER, 8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd255, 3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h00, 8'h00, 8'h00},
		// unused opcode is dropped
		'{OP_UNUSED, 8'hA5,  3'd5, 3'd6, 8'h5A,  3'd3, 8'hC3,  1'b1, 1'b1, 4'd9,  4'd6,
			1'b0, 8'h00, 8'h00, 8'h00},
		// white square at column 0, full life, slowest periods
		'{OP_LOAD,   8'd0,   3'd0, 3'd0, 8'd0,   3'd7, 8'd255, 1'b0, 1'b0, 4'd15, 4'd15,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h18, 8'h18, 8'h18},
		'{OP_RENDER, 8'd2,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h00, 8'h00, 8'h00},
		// last slot, o shape at the last column, one life, zero periods
		'{OP_LOAD,   8'd0,   3'd7, 3'd4, 8'd255, 3'd5, 8'd1,   1'b1, 1'b1, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd255, 3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h18, 8'h00, 8'h18},
		// wraps past the screen edge onto the square
		'{OP_RENDER, 8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		// life runs out: slot 7 dies without moving
		'{OP_TICK,   8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd255, 3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b1, 8'h00, 8'h00, 8'h00},
		// overlapping sprites of shapes 1 to 3, incl. invisible shapes 5 and 7
		'{OP_LOAD,   8'd0,   3'd1, 3'd1, 8'd10,  3'd2, 8'd3,   1'b0, 1'b0, 4'd1,  4'd1,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_LOAD,   8'd0,   3'd2, 3'd2, 8'd11,  3'd4, 8'd200, 1'b1, 1'b1, 4'd2,  4'd3,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_LOAD,   8'd0,   3'd3, 3'd3, 8'd12,  3'd1, 8'd50,  1'b0, 1'b0, 4'd1,  4'd2,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_LOAD,   8'd0,   3'd4, 3'd5, 8'd10,  3'd7, 8'd9,   1'b0, 1'b1, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_LOAD,   8'd0,   3'd5, 3'd7, 8'd11,  3'd6, 8'd255, 1'b1, 1'b0, 4'd15, 4'd15,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd11,  3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_TICK,   8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_TICK,   8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd12,  3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_TICK,   8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_TICK,   8'd0,   3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd11,  3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		// black sprite erases what lies under it
		'{OP_LOAD,   8'd0,   3'd2, 3'd0, 8'd11,  3'd0, 8'd10,  1'b0, 1'b0, 4'd3,  4'd1,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{OP_RENDER, 8'd11,  3'd0, 3'd0, 8'd0,   3'd0, 8'd0,   1'b0, 1'b0, 4'd0,  4'd0,
			1'b0, 8'h00, 8'h00, 8'h00},
		// load with zero life leaves the slot dead
		'{OP_LOAD,   8'd0,   3'd6, 3'd7, 8'd200, 3'd3, 8'd0,   1'b1, 1'b0, 4'd0,  4'd15,
			1'b0, 8'h00, 8'h00, 8'h00}
	};

	sprite_column_compositor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic scc_pkg::rgb_t compose_column(input logic [7:0] col);
		scc_pkg::rgb_t px;
		logic [7:0]    off;
		logic [7:0]    line;
		logic [7:0]    d;
		int            r;
		px = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (life_q[s] != 8'd0 && shape_q[s] < 3'd5) begin
				off = col - pos_q[s];
				if (int'(off) < glyph_w[shape_q[s]]) begin
					line = glyph[shape_q[s]][off[1:0]];
					r = $signed(roff_q[s]);
					if (r > 0)
						line = line >> r;
					else
						line = line << (-r);
					// top mask bit lands in bit 0
					for (int i = 0; i < 8; i++)
						d[7-i] = line[i];
					px.red   = (px.red   & ~d) | (color_q[s][2] ? d : 8'h00);
					px.green = (px.green & ~d) | (color_q[s][1] ? d : 8'h00);
					px.blue  = (px.blue  & ~d) | (color_q[s][0] ? d : 8'h00);
				end
			end
		end
		return px;
	endfunction

	function automatic void advance_sprites();
		logic [3:0] cc;
		logic [3:0] rc;
		int         lo;
		int         hi;
		int         r;
		logic [31:0] rv;
		for (int s = 0; s < SLOTS; s++) begin
			if (life_q[s] != 8'd0) begin
				cc = ccnt_q[s] + 4'd1;
				rc = rcnt_q[s] + 4'd1;
				if (cc >= cper_q[s]) begin
					life_q[s] = life_q[s] - 8'd1;
					// the move is skipped on the tick that kills the sprite
					if (life_q[s] != 8'd0) begin
						pos_q[s] = cdir_q[s] ? pos_q[s] - 8'd1 : pos_q[s] + 8'd1;
						cc = 4'd0;
					end
				end
				if (rc >= rper_q[s]) begin
					lo = (shape_q[s] < 3'd5) ? glyph_lo[shape_q[s]] : -3;
					hi = (shape_q[s] < 3'd5) ? glyph_hi[shape_q[s]] : 3;
					r  = $signed(roff_q[s]);
					r  = rdir_q[s] ? r - 1 : r + 1;
					rv = r;
					roff_q[s] = rv[2:0];
					r  = $signed(roff_q[s]);
					if (r >= hi || r <= lo)
						rdir_q[s] = ~rdir_q[s];
					rc = 4'd0;
				end
				ccnt_q[s] = cc;
				rcnt_q[s] = rc;
			end
		end
	endfunction

	function automatic void load_sprite(input scc_pkg::in_beat_t d);
		shape_q[d.slot] = d.shape;
		pos_q[d.slot]   = d.start_column;
		color_q[d.slot] = d.color;
		life_q[d.slot]  = d.life;
		cdir_q[d.slot]  = d.column_direction;
		rdir_q[d.slot]  = d.row_direction;
		cper_q[d.slot]  = d.column_period;
		rper_q[d.slot]  = d.row_period;
		roff_q[d.slot]  = 3'd0;
		ccnt_q[d.slot]  = 4'd0;
		rcnt_q[d.slot]  = 4'd0;
	endfunction

	// applied at the edge where the input beat is taken
	function automatic void apply_beat(input beat_t b);
		case (b.op)
			OP_RENDER: begin
				if (b.typed)
					column_px_q.push_back(b.want);
				else
					column_px_q.push_back(compose_column(b.data.column));
			end
			OP_TICK: advance_sprites();
			OP_LOAD: load_sprite(b.data);
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic beat_t random_beat();
		beat_t       b;
		logic [63:0] raw;
		int          pick;
		int          s;
		raw  = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		b.typed  = 1'b0;
		b.want   = '0;
		b.data   = {5'd0, raw[42:0]};
		if (pick < 12) begin
			b.op = OP_LOAD;
			// mostly visible shapes, clustered so sprites overlap
			b.data.shape = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
				: 3'($urandom_range(5, 7));
			if ($urandom_range(0, 99) < 70)
				b.data.start_column = cluster_base + 8'($urandom_range(0, 15));
			pick = $urandom_range(0, 99);
			if (pick < 5)
				b.data.life = 8'd0;
			else if (pick < 70)
				b.data.life = 8'($urandom_range(1, 12));
			if ($urandom_range(0, 99) < 70) begin
				b.data.column_period = 4'($urandom_range(0, 4));
				b.data.row_period    = 4'($urandom_range(0, 4));
			end
		end else if (pick < 50) begin
			b.op = OP_TICK;
		end else if (pick < 97) begin
			b.op = OP_RENDER;
			s = $urandom_range(0, SLOTS - 1);
			if ($urandom_range(0, 99) < 70) begin
				if (life_q[s] != 8'd0)
					b.data.column = pos_q[s] + 8'($urandom_range(0, 3));
				else
					b.data.column = cluster_base + 8'($urandom_range(0, 18));
			end
		end else begin
			b.op = OP_UNUSED;
		end
		return b;
	endfunction

	task automatic push_beat(input beat_t b);
		int gap;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= b.op;
		s_tdata  <= b.data;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		apply_beat(b);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ERROR %s expected %02h actual %02h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = m_tdata;
			if (column_px_q.size() == 0) begin
				$display("%0t ERROR unexpected column beat, expected none actual %06h",
					$time, m_tdata);
				errors++;
			end else begin
				mon_want = column_px_q.pop_front();
				check_field("red_bits",   mon_want.red,   mon_got.red_bits);
				check_field("green_bits", mon_want.green, mon_got.green_bits);
				check_field("blue_bits",  mon_want.blue,  mon_got.blue_bits);
			end
		end
	end

	// output side: random stalls per beat, plus one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end
			gap = recv_idle ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("%0t ERROR timeout, %0d column beats still pending", $time,
				column_px_q.size());
			$display("sprite_column_compositor: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		beat_t      b;
		logic [1:0] mode;
		int         hold_at;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_RENDER;
		for (int s = 0; s < SLOTS; s++) begin
			life_q[s]  = 8'd0;
			shape_q[s] = 3'd0;
			pos_q[s]   = 8'd0;
			roff_q[s]  = 3'd0;
			color_q[s] = 3'd0;
			cdir_q[s]  = 1'b0;
			rdir_q[s]  = 1'b0;
			cper_q[s]  = 4'd0;
			rper_q[s]  = 4'd0;
			ccnt_q[s]  = 4'd0;
			rcnt_q[s]  = 4'd0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			b.op    = dir_tab[i].op;
			b.data  = '0;
			b.data.column           = dir_tab[i].column;
			b.data.slot             = dir_tab[i].slot;
			b.data.shape            = dir_tab[i].shape;
			b.data.start_column     = dir_tab[i].start;
			b.data.color            = dir_tab[i].color;
			b.data.life             = dir_tab[i].life;
			b.data.column_direction = dir_tab[i].cdir;
			b.data.row_direction    = dir_tab[i].rdir;
			b.data.column_period    = dir_tab[i].cper;
			b.data.row_period       = dir_tab[i].rper;
			b.typed = dir_tab[i].typed;
			b.want  = '{red: dir_tab[i].red, green: dir_tab[i].green, blue: dir_tab[i].blue};
			push_beat(b);
		end

		// random traffic in phases; each phase picks which sides idle
		hold_at = $urandom_range(200, 800);
		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i % 100 == 0) begin
				mode = 2'($urandom_range(0, 3));
				send_idle = mode[0];
				recv_idle = mode[1];
			end
			if (i % 200 == 0)
				cluster_base = 8'($urandom_range(0, 255));
			if (i == hold_at)
				hold_req = 1'b1;
			push_beat(random_beat());
		end
		s_tvalid <= 1'b0;

		while (column_px_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0)
			$display("sprite_column_compositor: match");
		else
			$display("sprite_column_compositor: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/scc_pkg.sv
rtl/scc_slot_unit.sv
rtl/sprite_column_compositor.sv
sim/sprite_column_compositor_tb.sv
